// ===== hw/rtl/tlv_frame_decoder_crc16_assert.svh =====
// ----------------------------------------------------------------------------
// tlv frame decoder assertion macros
// shared property wrappers for the checker
// ----------------------------------------------------------------------------
`ifndef TLV_FRAME_DECODER_CRC16_ASSERT_SVH
`define TLV_FRAME_DECODER_CRC16_ASSERT_SVH

// same-cycle implication, quiet while in reset
`define TFD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication, quiet while in reset
`define TFD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== hw/rtl/tfd_pkg.sv =====
// ----------------------------------------------------------------------------
// tfd_pkg
// types, constants and the crc step shared by the tlv frame decoder
// ----------------------------------------------------------------------------
package tfd_pkg;

	localparam logic [7:0]  SYNC_BYTE  = 8'h5A;
	localparam logic [7:0]  ZERO_BYTE  = 8'h00;
	localparam logic [2:0]  HDR_LEN    = 3'd6;
	localparam logic [2:0]  CRC_LEN    = 3'd2;
	localparam logic [2:0]  POS_MAX    = 3'd7;
	localparam logic [15:0] CRC_POLY   = 16'h1021;

	typedef enum logic [1:0] {
		KIND_PARAM  = 2'd0,
		KIND_VALUE  = 2'd1,
		KIND_STATUS = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_HEADER    = 2'd1,
		ST_CRC       = 2'd2,
		ST_MALFORMED = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		PH_TYPE = 2'd0,
		PH_LEN  = 2'd1,
		PH_VAL  = 2'd2
	} phase_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  param_type;
		logic [7:0]  param_length;
		logic [7:0]  value_byte;
		logic [7:0]  value_index;
		logic [15:0] command;
		status_t     status;
		logic        last;
	} result_t;

	// results produced by one item, in delivery order
	typedef struct packed {
		logic [1:0] count;
		result_t    item0;
		result_t    item1;
	} step_out_t;

	// crc-16/xmodem, msb first, one byte
	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
		end
		return c;
	endfunction

endpackage

// ===== hw/rtl/tfd_core.sv =====
// ----------------------------------------------------------------------------
// tfd_core
// delay line, crc, header check and tlv parser state; one byte per step
// ----------------------------------------------------------------------------
module tfd_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  logic [7:0]          data_byte,
	input  logic                frame_end,
	output tfd_pkg::step_out_t  res
);
	import tfd_pkg::*;

	localparam logic [2:0] SHORT_LIM = HDR_LEN - CRC_LEN;

	logic [7:0]  held0_q, held1_q, held0_d, held1_d;
	logic [1:0]  held_cnt_q, held_cnt_d;
	logic [2:0]  pos_q, pos_d;
	logic [15:0] crc_q, crc_d;
	logic        hdr_good_q, hdr_good_d;
	phase_t      phase_q, phase_d;
	logic [7:0]  type_q, type_d;
	logic [7:0]  remain_q, remain_d;
	logic [7:0]  vpos_q, vpos_d;
	logic [15:0] cmd_q, cmd_d;

	result_t     rel_item, stat_item;
	logic        rel_valid;
	logic [7:0]  b, hi;
	logic        have_crc;
	logic [15:0] cmd_f;
	status_t     st;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held0_q    <= '0;
			held1_q    <= '0;
			held_cnt_q <= '0;
			pos_q      <= '0;
			crc_q      <= '0;
			hdr_good_q <= 1'b1;
			phase_q    <= PH_TYPE;
			type_q     <= '0;
			remain_q   <= '0;
			vpos_q     <= '0;
			cmd_q      <= '0;
		end else if (step) begin
			held0_q    <= held0_d;
			held1_q    <= held1_d;
			held_cnt_q <= held_cnt_d;
			pos_q      <= pos_d;
			crc_q      <= crc_d;
			hdr_good_q <= hdr_good_d;
			phase_q    <= phase_d;
			type_q     <= type_d;
			remain_q   <= remain_d;
			vpos_q     <= vpos_d;
			cmd_q      <= cmd_d;
		end
	end

	always_comb begin
		held0_d    = held0_q;
		held1_d    = held1_q;
		held_cnt_d = held_cnt_q;
		pos_d      = pos_q;
		crc_d      = crc_q;
		hdr_good_d = hdr_good_q;
		phase_d    = phase_q;
		type_d     = type_q;
		remain_d   = remain_q;
		vpos_d     = vpos_q;
		cmd_d      = cmd_q;
		rel_item   = '0;
		stat_item  = '0;
		rel_valid  = 1'b0;
		b          = held0_q;
		hi         = '0;
		have_crc   = 1'b0;
		cmd_f      = '0;
		st         = ST_OK;

		// oldest held byte leaves the delay line once two are held
		if (held_cnt_q == 2'd2) begin
			crc_d = crc_byte(crc_q, b);
			if (pos_q == 3'd0 && b != SYNC_BYTE) hdr_good_d = 1'b0;
			if (pos_q == 3'd3 && b != ZERO_BYTE) hdr_good_d = 1'b0;
			if (pos_q == 3'd4 || pos_q == 3'd5) cmd_d = {cmd_q[7:0], b};
			if (pos_q >= HDR_LEN) begin
				case (phase_q)
					PH_LEN: begin
						remain_d              = b;
						vpos_d                = '0;
						rel_valid             = 1'b1;
						rel_item.kind         = KIND_PARAM;
						rel_item.param_type   = type_q;
						rel_item.param_length = b;
						rel_item.command      = cmd_q;
						phase_d               = (b != 8'd0) ? PH_VAL : PH_TYPE;
					end
					PH_VAL: begin
						rel_valid             = 1'b1;
						rel_item.kind         = KIND_VALUE;
						rel_item.param_type   = type_q;
						rel_item.param_length = vpos_q + remain_q;
						rel_item.value_byte   = b;
						rel_item.value_index  = vpos_q;
						rel_item.command      = cmd_q;
						vpos_d                = vpos_q + 8'd1;
						remain_d              = remain_q - 8'd1;
						if (remain_d == 8'd0) phase_d = PH_TYPE;
					end
					default: begin
						type_d  = b;
						phase_d = PH_LEN;
					end
				endcase
			end
			if (pos_q < POS_MAX) pos_d = pos_q + 3'd1;
		end

		if (!frame_end) begin
			if (held_cnt_q == 2'd2) begin
				held0_d = held1_q;
				held1_d = data_byte;
			end else begin
				if (held_cnt_q[0]) held1_d = data_byte;
				else held0_d = data_byte;
				held_cnt_d = held_cnt_q + 2'd1;
			end
		end else begin
			have_crc = (held_cnt_q != 2'd0);
			if (held_cnt_q == 2'd2) hi = held1_q;
			else if (held_cnt_q == 2'd1) hi = held0_q;

			// short frames borrow crc bytes for the command word
			if (pos_d == 3'd4) cmd_f = {hi, data_byte};
			else if (pos_d == 3'd5) cmd_f = {cmd_d[7:0], hi};
			else cmd_f = cmd_d;

			if (!have_crc || pos_d < SHORT_LIM || !hdr_good_d) st = ST_HEADER;
			else if (crc_d != {hi, data_byte}) st = ST_CRC;
			else if (phase_d == PH_LEN || phase_d == PH_VAL) st = ST_MALFORMED;
			else st = ST_OK;

			stat_item.kind    = KIND_STATUS;
			stat_item.command = cmd_f;
			stat_item.status  = st;
			stat_item.last    = 1'b1;

			held0_d    = '0;
			held1_d    = '0;
			held_cnt_d = '0;
			pos_d      = '0;
			crc_d      = '0;
			hdr_good_d = 1'b1;
			phase_d    = PH_TYPE;
			type_d     = '0;
			remain_d   = '0;
			vpos_d     = '0;
			cmd_d      = '0;
		end

		res.count = {1'b0, rel_valid} + {1'b0, frame_end};
		res.item0 = rel_valid ? rel_item : stat_item;
		res.item1 = stat_item;
	end

endmodule

// ===== hw/rtl/tfd_outq.sv =====
// ----------------------------------------------------------------------------
// tfd_outq
// four-entry result queue, takes up to two results a cycle, gives one
// ----------------------------------------------------------------------------
module tfd_outq (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  tfd_pkg::step_out_t  push_data,
	input  logic                pop,
	output logic                room,
	output logic                head_valid,
	output tfd_pkg::result_t    head
);
	import tfd_pkg::*;

	result_t    entry_q [4];
	logic [1:0] wr_ptr_q, rd_ptr_q;
	logic [2:0] cnt_q;
	logic [1:0] n_push;
	logic       do_pop;

	assign n_push     = push ? push_data.count : 2'd0;
	assign head_valid = (cnt_q != 3'd0);
	assign do_pop     = pop && head_valid;
	assign room       = (cnt_q <= 3'd2);
	assign head       = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (n_push != 2'd0) entry_q[wr_ptr_q] <= push_data.item0;
		if (n_push == 2'd2) entry_q[wr_ptr_q + 2'd1] <= push_data.item1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + n_push;
			if (do_pop) rd_ptr_q <= rd_ptr_q + 2'd1;
			cnt_q <= cnt_q + {1'b0, n_push} - {2'b00, do_pop};
		end
	end

endmodule

// ===== hw/rtl/tlv_frame_decoder_crc16.sv =====
// path: an accepted item is held in the input register, and its results are written to the
// result queue, whose head drives out. throughput: one item per cycle while the queue has room;
// a frame end that also releases a parameter byte makes two results, given out one after the other
// the rate is set by the four-entry result queue and the output handshake
// reset: arst_n clears the parser state, the input valid flag and the queue pointers at once
// ----------------------------------------------------------------------------
// tlv_frame_decoder_crc16
// streaming decoder for tlv frames closed by a crc-16/xmodem
// ----------------------------------------------------------------------------
module tlv_frame_decoder_crc16 (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        frame_end,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  result_kind,
	output logic [7:0]  param_type,
	output logic [7:0]  param_length,
	output logic [7:0]  value_byte,
	output logic [7:0]  value_index,
	output logic [15:0] command,
	output logic [1:0]  status,
	output logic        last
);
	import tfd_pkg::*;

	logic      valid_s1;
	logic [7:0] byte_s1;
	logic      fin_s1;
	logic      step;
	logic      room;
	step_out_t step_res;
	result_t   head;

	assign step     = valid_s1 && room;
	assign in_ready = !valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= data_byte;
			fin_s1  <= frame_end;
		end
	end

	tfd_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.data_byte (byte_s1),
		.frame_end (fin_s1),
		.res       (step_res)
	);

	tfd_outq u_outq (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (step),
		.push_data  (step_res),
		.pop        (out_ready),
		.room       (room),
		.head_valid (out_valid),
		.head       (head)
	);

	assign result_kind  = head.kind;
	assign param_type   = head.param_type;
	assign param_length = head.param_length;
	assign value_byte   = head.value_byte;
	assign value_index  = head.value_index;
	assign command      = head.command;
	assign status       = head.status;
	assign last         = head.last;

endmodule

// ===== hw/rtl/tfd_checker.sv =====
// ----------------------------------------------------------------------------
// tfd_checker
// port-level checks on the tlv frame decoder results
// ----------------------------------------------------------------------------
`include "tlv_frame_decoder_crc16_assert.svh"

module tfd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [1:0]  result_kind,
	input logic [7:0]  value_byte,
	input logic [7:0]  value_index,
	input logic [1:0]  status,
	input logic        last
);
	import tfd_pkg::*;

	// a stalled result stays offered
	`TFD_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid)

	// only the status item closes a frame
	`TFD_ASSERT_NOW(a_last_is_status, clk, arst_n, out_valid && last, result_kind == KIND_STATUS)

	// parameter and value items carry no status and never close the frame
	`TFD_ASSERT_NOW(a_body_no_status, clk, arst_n, out_valid && result_kind != KIND_STATUS, status == ST_OK && !last)

	// a parameter start has no value fields
	`TFD_ASSERT_NOW(a_param_no_value, clk, arst_n, out_valid && result_kind == KIND_PARAM, value_byte == 8'd0 && value_index == 8'd0)

endmodule

bind tlv_frame_decoder_crc16 tfd_checker u_tfd_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.result_kind (result_kind),
	.value_byte  (value_byte),
	.value_index (value_index),
	.status      (status),
	.last        (last)
);

// ===== tb/tb_tlv_frame_decoder_crc16.sv =====
// ----------------------------------------------------------------------------
// tb_tlv_frame_decoder_crc16
// self-checking bench: frames are streamed byte by byte through the decoder and
// every result item is checked against a cycle-free model of the parser, the
// header checks and the crc-16/xmodem trailer, with random idling on both sides
// ----------------------------------------------------------------------------
module tb_tlv_frame_decoder_crc16;
	timeunit 1ns;
	timeprecision 1ps;

	import tfd_pkg::*;

	typedef enum logic [1:0] {
		SRC_LIT,
		SRC_CRC_HI,
		SRC_CRC_LO
	} byte_src_t;

	typedef enum logic [1:0] {
		RX_OPEN,
		RX_COIN,
		RX_EVERY_THIRD,
		RX_SPARSE
	} rx_mode_t;

	typedef struct packed {
		logic [7:0]  data;
		logic        fin;
		byte_src_t   src;
		logic        typed;
		status_t     st;
		logic [15:0] cmd;
	} dir_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  data_byte = 8'h00;
	logic        frame_end = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [1:0]  result_kind;
	logic [7:0]  param_type;
	logic [7:0]  param_length;
	logic [7:0]  value_byte;
	logic [7:0]  value_index;
	logic [15:0] command;
	logic [1:0]  status;
	logic        last;

	tlv_frame_decoder_crc16 dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.data_byte    (data_byte),
		.frame_end    (frame_end),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.result_kind  (result_kind),
		.param_type   (param_type),
		.param_length (param_length),
		.value_byte   (value_byte),
		.value_index  (value_index),
		.command      (command),
		.status       (status),
		.last         (last)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// decoder model state
	logic [7:0]  hold_q [2];
	logic [1:0]  hold_n;
	logic [2:0]  pos_n;
	logic [15:0] crc_acc;
	logic        hdr_ok;
	phase_t      phase;
	logic [7:0]  cur_type;
	logic [7:0]  remain;
	logic [7:0]  vpos;
	logic [15:0] cmd_word;

	result_t     pending_results [$];
	logic [7:0]  frame_bytes [$];

	int fail_count = 0;
	int items_sent = 0;
	int frames_sent = 0;
	int drain_pauses = 0;
	int results_checked = 0;
	int params_seen = 0;
	int values_seen = 0;
	int status_seen [4] = '{0, 0, 0, 0};
	int burst_left = 0;

	// one-byte frame, status with command from the crc, ok frame, bad sync at the end
	dir_row_t directed_rows [0:24] = '{
		'{8'hFF, 1'b1, SRC_LIT,    1'b1, ST_HEADER, 16'h0000},
		'{8'h5A, 1'b0, SRC_LIT,    1'b0, ST_OK,     16'h0000},
		'{8'h12, 1'b0, SRC_LIT,    1'b0, ST_OK,     16'h0000},
		'{8'h34, 1'b0, SRC_LIT,    1'b0, ST_OK,     16'h0000},
		'{8'h00, 1'b0, SRC_LIT,    1'b0, ST_OK,     16'h0000},
		'{8'h00, 1'b0, SRC_CRC_HI, 1'b0, ST_OK,     16'h0000},
		'{8'h00, 1'b1, SRC_CRC_LO, 1'b0, ST_OK,     16'h0000},
		'{8'h5A, 1'b0, SRC_LIT,    1'b0, ST_OK,     16'h0000},
		'{8'h00, 1'b0, SRC_LIT,    1'b0, ST_OK,     16'h0000},
		'{8'h00, 1'b0, SRC_LIT,    1'b0, ST_OK,     16'h0000},
		'{8'h00, 1'b0, SRC_LIT,    1'b0, ST_OK,     16'h0000},
		'{8'hAB, 1'b0, SRC_LIT,    1'b0, ST_OK,     16'h0000},
		'{8'hCD, 1'b0, SRC_LIT,    1'b0, ST_OK,     16'h0000},
		'{8'h01, 1'b0, SRC_LIT,    1'b0, ST_OK,     16'h0000},
		'{8'h02, 1'b0, SRC_LIT,    1'b0, ST_OK,     16'h0000},
		'{8'h11, 1'b0, SRC_LIT,    1'b0, ST_OK,     16'h0000},
		'{8'h22, 1'b0, SRC_LIT,    1'b0, ST_OK,     16'h0000},
		'{8'hFF, 1'b0, SRC_LIT,    1'b0, ST_OK,     16'h0000},
		'{8'h00, 1'b0, SRC_LIT,    1'b0, ST_OK,     16'h0000},
		'{8'h00, 1'b0, SRC_CRC_HI, 1'b0, ST_OK,     16'h0000},
		'{8'h00, 1'b1, SRC_CRC_LO, 1'b0, ST_OK,     16'h0000},
		'{8'h00, 1'b0, SRC_LIT,    1'b0, ST_OK,     16'h0000},
		'{8'h00, 1'b0, SRC_LIT,    1'b0, ST_OK,     16'h0000},
		'{8'h00, 1'b0, SRC_LIT,    1'b0, ST_OK,     16'h0000},
		'{8'h00, 1'b1, SRC_LIT,    1'b1, ST_HEADER, 16'h0000}
	};

	// bit-serial form of the xmodem crc
	function automatic logic [15:0] crc16_xmodem_step(input logic [15:0] c, input logic [7:0] b);
		logic fb;
		for (int i = 7; i >= 0; i--) begin
			fb = c[15] ^ b[i];
			c = {c[14:0], 1'b0};
			if (fb) begin
				c = c ^ CRC_POLY;
			end
		end
		return c;
	endfunction

	// expected result goes to the tail of the queue
	task automatic add_result(input result_t r);
		pending_results = {pending_results, r};
	endtask

	task automatic add_frame_byte(input logic [7:0] v);
		frame_bytes = {frame_bytes, v};
	endtask

	task automatic clear_decoder();
		hold_q[0] = 8'h00;
		hold_q[1] = 8'h00;
		hold_n = 2'd0;
		pos_n = 3'd0;
		crc_acc = 16'h0000;
		hdr_ok = 1'b1;
		phase = PH_TYPE;
		cur_type = 8'h00;
		remain = 8'h00;
		vpos = 8'h00;
		cmd_word = 16'h0000;
	endtask

	// a byte leaving the crc delay line: header check or tlv parse
	task automatic decode_body_byte(input logic [7:0] b);
		result_t r;
		r = '0;
		crc_acc = crc16_xmodem_step(crc_acc, b);
		if (pos_n == 3'd0 && b != SYNC_BYTE) hdr_ok = 1'b0;
		if (pos_n == 3'd3 && b != ZERO_BYTE) hdr_ok = 1'b0;
		if (pos_n == 3'd4 || pos_n == 3'd5) cmd_word = {cmd_word[7:0], b};
		if (pos_n >= HDR_LEN) begin
			case (phase)
				PH_LEN: begin
					remain = b;
					vpos = 8'h00;
					r.kind = KIND_PARAM;
					r.param_type = cur_type;
					r.param_length = b;
					r.command = cmd_word;
					add_result(r);
					phase = (b != 8'h00) ? PH_VAL : PH_TYPE;
				end
				PH_VAL: begin
					r.kind = KIND_VALUE;
					r.param_type = cur_type;
					r.param_length = vpos + remain;
					r.value_byte = b;
					r.value_index = vpos;
					r.command = cmd_word;
					add_result(r);
					vpos = vpos + 8'd1;
					remain = remain - 8'd1;
					if (remain == 8'h00) phase = PH_TYPE;
				end
				default: begin
					cur_type = b;
					phase = PH_LEN;
				end
			endcase
		end
		if (pos_n != POS_MAX) pos_n = pos_n + 3'd1;
	endtask

	task automatic predict_frame_byte(input logic [7:0] b, input logic fin);
		result_t     r;
		logic [7:0]  hi;
		logic        have_crc;
		logic [15:0] cmd;
		status_t     st;
		if (!fin) begin
			if (hold_n == 2'd2) begin
				decode_body_byte(hold_q[0]);
				hold_q[0] = hold_q[1];
				hold_q[1] = b;
			end else begin
				hold_q[hold_n[0]] = b;
				hold_n = hold_n + 2'd1;
			end
		end else begin
			hi = 8'h00;
			have_crc = 1'b1;
			if (hold_n == 2'd2) begin
				decode_body_byte(hold_q[0]);
				hi = hold_q[1];
			end else if (hold_n == 2'd1) begin
				hi = hold_q[0];
			end else begin
				have_crc = 1'b0;
			end
			// short frames borrow command bytes from the crc trailer
			if (pos_n == 3'd4) cmd = {hi, b};
			else if (pos_n == 3'd5) cmd = {cmd_word[7:0], hi};
			else cmd = cmd_word;
			if (!have_crc || int'(pos_n) + int'(CRC_LEN) < int'(HDR_LEN) || !hdr_ok)
				st = ST_HEADER;
			else if (crc_acc != {hi, b})
				st = ST_CRC;
			else if (phase == PH_LEN || phase == PH_VAL)
				st = ST_MALFORMED;
			else
				st = ST_OK;
			r = '0;
			r.kind = KIND_STATUS;
			r.command = cmd;
			r.status = st;
			r.last = 1'b1;
			add_result(r);
			clear_decoder();
		end
	endtask

	// called on a falling edge, returns on a falling edge
	task automatic send_byte(input logic [7:0] b, input logic fin, input logic use_typed,
			input status_t t_st, input logic [15:0] t_cmd);
		int      gap;
		result_t typed_res;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 7) == 0) ? 300 : $urandom_range(1, 40);
			gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 20) : $urandom_range(0, 4);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		in_valid <= 1'b1;
		data_byte <= b;
		frame_end <= fin;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		predict_frame_byte(b, fin);
		if (use_typed) begin
			typed_res = '0;
			typed_res.kind = KIND_STATUS;
			typed_res.command = t_cmd;
			typed_res.status = t_st;
			typed_res.last = 1'b1;
			void'(pending_results.pop_back());
			add_result(typed_res);
		end
		burst_left--;
		items_sent++;
		@(negedge clk);
	endtask

	task automatic drain_wait();
		in_valid <= 1'b0;
		@(negedge clk);
		while (pending_results.size() != 0) @(negedge clk);
		drain_pauses++;
	endtask

	// well-formed header and parameters, no trailer yet
	task automatic build_body(input int nparams, input logic long_value);
		int len;
		frame_bytes = {};
		add_frame_byte(SYNC_BYTE);
		add_frame_byte(8'($urandom));
		add_frame_byte(8'($urandom));
		add_frame_byte(ZERO_BYTE);
		add_frame_byte(8'($urandom));
		add_frame_byte(8'($urandom));
		for (int p = 0; p < nparams; p++) begin
			if (long_value && p == 0) len = $urandom_range(200, 255);
			else if ($urandom_range(0, 7) == 0) len = 0;
			else len = $urandom_range(1, 6);
			add_frame_byte(8'($urandom));
			add_frame_byte(8'(len));
			repeat (len) add_frame_byte(8'($urandom));
		end
	endtask

	task automatic append_crc();
		logic [15:0] c;
		c = 16'h0000;
		foreach (frame_bytes[i]) c = crc16_xmodem_step(c, frame_bytes[i]);
		add_frame_byte(c[15:8]);
		add_frame_byte(c[7:0]);
	endtask

	task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk) begin : result_check
		result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$error("result item with nothing pending: kind %0d status %0d", result_kind, status);
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				check_field("result_kind", 16'(want.kind), 16'(result_kind));
				check_field("param_type", 16'(want.param_type), 16'(param_type));
				check_field("param_length", 16'(want.param_length), 16'(param_length));
				check_field("value_byte", 16'(want.value_byte), 16'(value_byte));
				check_field("value_index", 16'(want.value_index), 16'(value_index));
				check_field("command", want.command, command);
				check_field("status", 16'(want.status), 16'(status));
				check_field("last", 16'(want.last), 16'(last));
				results_checked++;
				case (want.kind)
					KIND_PARAM: params_seen++;
					KIND_VALUE: values_seen++;
					default: status_seen[want.status]++;
				endcase
			end
		end
	end

	// receiver stall pattern; its mode is picked anew each time rx_left runs out
	rx_mode_t rx_mode = RX_OPEN;
	int       rx_left = 0;
	int       rx_tick = 0;

	always @(negedge clk) begin
		if (rx_left == 0) begin
			rx_mode = rx_mode_t'($urandom_range(0, 3));
			rx_left = $urandom_range(20, 120);
		end
		rx_left--;
		rx_tick++;
		case (rx_mode)
			RX_OPEN:        out_ready <= 1'b1;
			RX_COIN:        out_ready <= 1'($urandom_range(0, 1));
			RX_EVERY_THIRD: out_ready <= (rx_tick % 3 == 0);
			default:        out_ready <= ($urandom_range(0, 7) == 0);
		endcase
	end

	initial begin
		#4_000_000;
		$display("FAIL tlv_frame_decoder_crc16");
		$finish;
	end

	initial begin
		dir_row_t    row;
		logic [15:0] dir_crc;
		logic [7:0]  b;
		int          pick;
		int          k;
		logic        long_value;
		clear_decoder();
		dir_crc = 16'h0000;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int i = 0; i < 25; i++) begin
			row = directed_rows[i];
			case (row.src)
				SRC_CRC_HI: b = dir_crc[15:8];
				SRC_CRC_LO: b = dir_crc[7:0];
				default: begin
					b = row.data;
					dir_crc = crc16_xmodem_step(dir_crc, b);
				end
			endcase
			send_byte(b, row.fin, row.typed, row.st, row.cmd);
			if (row.fin) begin
				dir_crc = 16'h0000;
				frames_sent++;
			end
		end
		drain_wait();

		while (items_sent < 1800) begin
			pick = $urandom_range(0, 99);
			long_value = (frames_sent == 4) || ($urandom_range(0, 99) == 0);
			if (pick < 65) begin
				build_body($urandom_range(0, 4), long_value);
				append_crc();
			end else if (pick < 73) begin
				// corrupted trailer
				build_body($urandom_range(0, 4), long_value);
				append_crc();
				k = frame_bytes.size() - 1 - $urandom_range(0, 1);
				frame_bytes[k] = frame_bytes[k] ^ (8'h01 << $urandom_range(0, 7));
			end else if (pick < 79) begin
				build_body($urandom_range(0, 3), 1'b0);
				if ($urandom_range(0, 1) == 0)
					frame_bytes[0] = SYNC_BYTE ^ 8'($urandom_range(1, 255));
				else
					frame_bytes[3] = 8'($urandom_range(1, 255));
				append_crc();
			end else if (pick < 87) begin
				// parameter cut off before the trailer
				build_body($urandom_range(1, 4), long_value);
				k = $urandom_range(1, 3);
				if (frame_bytes.size() - k >= 6) repeat (k) void'(frame_bytes.pop_back());
				append_crc();
			end else if (pick < 93) begin
				if ($urandom_range(0, 1) == 0) begin
					build_body(0, 1'b0);
					k = $urandom_range(0, 5);
					while (frame_bytes.size() > k) void'(frame_bytes.pop_back());
					append_crc();
				end else begin
					frame_bytes = {};
					repeat ($urandom_range(1, 7)) add_frame_byte(8'($urandom));
				end
			end else begin
				frame_bytes = {};
				repeat ($urandom_range(1, 30)) add_frame_byte(8'($urandom));
			end
			if ($urandom_range(0, 49) == 0) drain_wait();
			for (int i = 0; i < frame_bytes.size(); i++)
				send_byte(frame_bytes[i], i == frame_bytes.size() - 1, 1'b0, ST_OK, 16'h0000);
			frames_sent++;
		end

		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
		// catch anything the decoder emits beyond what was predicted
		repeat (10) @(negedge clk);

		$display("run covered %0d frames, %0d bytes, %0d drain pauses; %0d results checked",
			frames_sent, items_sent, drain_pauses, results_checked);
		$display("params %0d, value bytes %0d; status ok %0d header %0d crc %0d malformed %0d",
			params_seen, values_seen, status_seen[0], status_seen[1], status_seen[2],
			status_seen[3]);
		if (fail_count == 0) begin
			$display("PASS tlv_frame_decoder_crc16");
		end else begin
			$display("FAIL tlv_frame_decoder_crc16");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/tfd_pkg.sv
hw/rtl/tfd_core.sv
hw/rtl/tfd_outq.sv
hw/rtl/tlv_frame_decoder_crc16.sv
hw/rtl/tfd_checker.sv
tb/tb_tlv_frame_decoder_crc16.sv
